FILE: rtl/bnrm_pkg.sv
// ----------------------------------------------------------------------------
// bnrm_pkg
// Shared types, constants and helpers for the breakout next-return mean block.
// ----------------------------------------------------------------------------
package bnrm_pkg;

	localparam int unsigned PRICE_W     = 32;
	localparam int unsigned RET_W       = 32;
	localparam int unsigned SUM_W       = 64;
	localparam int unsigned COUNT_W     = 17;
	localparam int unsigned FRAC_BITS   = 16;
	localparam int unsigned ITER_W      = 7;
	localparam int unsigned RET_ITERS   = PRICE_W + FRAC_BITS;
	localparam int unsigned MEAN_ITERS  = SUM_W;

	localparam logic [COUNT_W-1:0] COUNT_LIMIT = {COUNT_W{1'b1}};
	localparam logic [SUM_W-1:0]   POS_LIMIT   = 64'h0000_0000_7fff_ffff;
	localparam logic [SUM_W-1:0]   NEG_LIMIT   = 64'h0000_0000_8000_0000;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETTLE,
		ST_RET_DIV,
		ST_FINISH,
		ST_MEAN_DIV,
		ST_EMIT
	} state_t;

	// request to the shared divider
	typedef struct packed {
		logic              start;
		logic [ITER_W-1:0] iters;
	} div_req_t;

	// saturate a quotient magnitude to the signed 32-bit range
	function automatic logic [RET_W-1:0] sat_signed(input logic [SUM_W-1:0] q,
	                                                input logic neg);
		logic [RET_W-1:0] r;
		if (neg) begin
			if (q > NEG_LIMIT) r = NEG_LIMIT[RET_W-1:0];
			else               r = RET_W'(~q[RET_W-1:0] + 1'b1);
		end else begin
			if (q > POS_LIMIT) r = POS_LIMIT[RET_W-1:0];
			else               r = q[RET_W-1:0];
		end
		return r;
	endfunction

endpackage

FILE: rtl/bnrm_if.sv
// ----------------------------------------------------------------------------
// bnrm channel interfaces
// Valid/ready channels for price samples and for mean results.
// ----------------------------------------------------------------------------
interface bnrm_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] price;
	logic        price_valid;
	logic        series_last;

	modport source (output valid, price, price_valid, series_last, input ready);
	modport sink   (input valid, price, price_valid, series_last, output ready);
endinterface

interface bnrm_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] mean_return;
	logic               has_result;

	modport source (output valid, mean_return, has_result, input ready);
	modport sink   (input valid, mean_return, has_result, output ready);
endinterface

FILE: rtl/bnrm_div.sv
// ----------------------------------------------------------------------------
// bnrm_div
// Shared restoring radix-2 divider, one quotient bit per cycle, msb first.
// ----------------------------------------------------------------------------
module bnrm_div
	import bnrm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  div_req_t         req,
	input  logic [SUM_W-1:0] dividend,
	input  logic [31:0]      divisor,
	output logic             done,
	output logic [SUM_W-1:0] quotient
);

	logic [SUM_W-1:0]  dq_q;
	logic [31:0]       rem_q;
	logic [31:0]       dvs_q;
	logic [ITER_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [32:0]       rem_shift;
	logic [32:0]       diff;

	// one trial subtraction
	assign rem_shift = {rem_q, dq_q[SUM_W-1]};
	assign diff      = rem_shift - {1'b0, dvs_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !req.start && busy_q && (cnt_q == ITER_W'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.iters;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == ITER_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[32]) begin
				rem_q <= diff[31:0];
				dq_q  <= {dq_q[SUM_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_shift[31:0];
				dq_q  <= {dq_q[SUM_W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = dq_q;

endmodule

FILE: rtl/breakout_next_return_mean.sv
// ----------------------------------------------------------------------------
// breakout_next_return_mean
// Tracks the running high of a price series, averages the return of the
// sample that follows each new high, and reports the mean on the last sample.
// ----------------------------------------------------------------------------
//  channel   dir  fields                                   role
//  samples   in   price, price_valid, series_last          one price request
//  results   out  mean_return (Q16 signed), has_result     one per series end
//
//  A sample passes settle and finish, with a return division in between
//  when it settles a pending high; the shared radix-2 divider gives one
//  quotient bit per cycle (48 bits for a return). A last sample adds the
//  64-bit mean division if a return was counted, and any wait for output.
//  samples.ready is high only in idle; a held result does not block intake
//  until the next series end needs the output register.
//  Reset clears the running high, pending price, sum, count and result valid.
// ----------------------------------------------------------------------------
module breakout_next_return_mean
	import bnrm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	bnrm_in_if.sink    samples,
	bnrm_out_if.source results
);

	state_t state_q, state_d;

	logic [PRICE_W-1:0] price_q;
	logic               usable_q;
	logic               last_q;
	logic [PRICE_W-1:0] high_q;
	logic               seen_q;
	logic [PRICE_W-1:0] pend_q;
	logic               pend_flag_q;
	logic [SUM_W-1:0]   sum_q;
	logic [COUNT_W-1:0] count_q;
	logic               neg_q;
	logic               out_valid_q;
	logic [RET_W-1:0]   out_ret_q;
	logic               out_has_q;

	div_req_t           div_req;
	logic [SUM_W-1:0]   div_dividend;
	logic [31:0]        div_divisor;
	logic               div_done;
	logic [SUM_W-1:0]   div_quot;

	logic               accept;
	logic               do_return;
	logic               ret_neg;
	logic [PRICE_W-1:0] ret_mag;
	logic               sum_neg;
	logic [SUM_W-1:0]   sum_mag;
	logic [RET_W-1:0]   sat_val;
	logic               emit_go;

	assign accept  = samples.valid && samples.ready;
	assign emit_go = !out_valid_q || results.ready;

	// settle decision and operand magnitudes
	assign do_return = pend_flag_q && usable_q && (count_q < COUNT_LIMIT);
	assign ret_neg   = price_q < pend_q;
	assign ret_mag   = ret_neg ? (pend_q - price_q) : (price_q - pend_q);
	assign sum_neg   = sum_q[SUM_W-1];
	assign sum_mag   = sum_neg ? (~sum_q + 1'b1) : sum_q;
	assign sat_val   = sat_signed(div_quot, neg_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:     if (accept) state_d = ST_SETTLE;
			ST_SETTLE:   state_d = do_return ? ST_RET_DIV : ST_FINISH;
			ST_RET_DIV:  if (div_done) state_d = ST_FINISH;
			ST_FINISH: begin
				if (!last_q)              state_d = ST_IDLE;
				else if (count_q == '0)   state_d = ST_EMIT;
				else                      state_d = ST_MEAN_DIV;
			end
			ST_MEAN_DIV: if (div_done) state_d = ST_EMIT;
			ST_EMIT:     if (emit_go) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// divider requests and operands
	always_comb begin
		div_req      = '0;
		div_dividend = {ret_mag, 32'b0};
		div_divisor  = pend_q;
		unique case (state_q)
			ST_SETTLE: begin
				div_req.start = do_return;
				div_req.iters = ITER_W'(RET_ITERS);
			end
			ST_FINISH: begin
				div_req.start = last_q && (count_q != '0);
				div_req.iters = ITER_W'(MEAN_ITERS);
				div_dividend  = sum_mag;
				div_divisor   = 32'(count_q);
			end
			default: ;
		endcase
	end

	assign samples.ready = (state_q == ST_IDLE);

	bnrm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			high_q      <= '0;
			seen_q      <= 1'b0;
			pend_q      <= '0;
			pend_flag_q <= 1'b0;
			sum_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// result valid: set on emit, cleared when taken
			if (state_q == ST_EMIT && emit_go) out_valid_q <= 1'b1;
			else if (results.ready)            out_valid_q <= 1'b0;
			unique case (state_q)
				ST_SETTLE: pend_flag_q <= 1'b0;
				ST_RET_DIV: begin
					if (div_done) begin
						sum_q   <= sum_q + {{(SUM_W-RET_W){sat_val[RET_W-1]}}, sat_val};
						count_q <= count_q + 1'b1;
					end
				end
				ST_FINISH: begin
					// a non-final usable price above the high, or the first one, becomes pending
					if (!last_q && usable_q && (!seen_q || price_q > high_q)) begin
						high_q      <= price_q;
						seen_q      <= 1'b1;
						pend_q      <= price_q;
						pend_flag_q <= 1'b1;
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						high_q      <= '0;
						seen_q      <= 1'b0;
						pend_q      <= '0;
						pend_flag_q <= 1'b0;
						sum_q       <= '0;
						count_q     <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			price_q  <= samples.price;
			usable_q <= samples.price_valid && (samples.price != '0);
			last_q   <= samples.series_last;
		end
		if (state_q == ST_SETTLE) neg_q <= ret_neg;
		if (state_q == ST_FINISH) begin
			neg_q     <= sum_neg;
			out_ret_q <= '0;
			out_has_q <= 1'b0;
		end
		if (state_q == ST_MEAN_DIV && div_done) begin
			out_ret_q <= sat_val;
			out_has_q <= 1'b1;
		end
	end

	// output register
	logic [RET_W-1:0] res_ret_q;
	logic             res_has_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && emit_go) begin
			res_ret_q <= out_ret_q;
			res_has_q <= out_has_q;
		end
	end

	assign results.valid       = out_valid_q;
	assign results.mean_return = res_ret_q;
	assign results.has_result  = res_has_q;

endmodule

FILE: bench/bnrm_mean_checker.sv
// ----------------------------------------------------------------------------
// bnrm_mean_checker
// Watches the sample and result channels of the breakout next-return mean
// block, keeps its own copy of the series state, works out the mean due at
// every series end and compares each delivered result field by field.
// ----------------------------------------------------------------------------
module bnrm_mean_checker
	import bnrm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	bnrm_in_if          samples,
	bnrm_out_if         results,
	output int unsigned fail_count,
	output int unsigned means_waiting
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic signed [RET_W-1:0] mean;
		logic                    has;
	} mean_exp_t;

	// series state of the predictor
	logic [PRICE_W-1:0] high_price;
	logic               high_valid;
	logic [PRICE_W-1:0] breakout_price;
	logic               breakout_open;
	logic [SUM_W-1:0]   ret_sum;
	logic [COUNT_W-1:0] ret_count;

	mean_exp_t   expected_means[$];
	int unsigned mismatches = 0;
	int unsigned means_seen = 0;

	assign fail_count = mismatches;

	// Q16 return of nxt over base minus one, saturated, two's complement in 64 bits
	function automatic logic [SUM_W-1:0] breakout_return(input logic [PRICE_W-1:0] base,
	                                                      input logic [PRICE_W-1:0] nxt);
		logic             below;
		logic [SUM_W-1:0] mag;
		logic [SUM_W-1:0] q;
		below = nxt < base;
		mag = below ? {32'd0, base - nxt} : {32'd0, nxt - base};
		q = (mag << FRAC_BITS) / {32'd0, base};
		if (below) begin
			if (q > NEG_LIMIT) q = NEG_LIMIT;
			return 64'd0 - q;
		end
		if (q > POS_LIMIT) q = POS_LIMIT;
		return q;
	endfunction

	// signed mean of the return sum, truncated toward zero and saturated
	function automatic logic [RET_W-1:0] series_mean(input logic [SUM_W-1:0] sum,
	                                                  input logic [COUNT_W-1:0] count);
		logic             neg;
		logic [SUM_W-1:0] mag;
		logic [SUM_W-1:0] q;
		neg = sum[SUM_W-1];
		mag = neg ? 64'd0 - sum : sum;
		q = mag / {47'd0, count};
		if (neg) begin
			if (q > NEG_LIMIT) q = NEG_LIMIT;
			q = 64'd0 - q;
		end else if (q > POS_LIMIT) begin
			q = POS_LIMIT;
		end
		return q[RET_W-1:0];
	endfunction

	task automatic clear_series();
		high_price     = '0;
		high_valid     = 1'b0;
		breakout_price = '0;
		breakout_open  = 1'b0;
		ret_sum        = '0;
		ret_count      = '0;
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
	                               input logic [31:0] want);
		mismatches++;
		if (mismatches <= 40)
			$display("%0t mismatch on mean %0d: %s got %0h expected %0h",
			         $realtime, means_seen, what, got, want);
	endtask

	// advance the series state by one accepted sample request
	task automatic take_sample(input logic [PRICE_W-1:0] p, input logic pv, input logic last);
		logic      usable;
		mean_exp_t m;
		usable = pv && (p != '0);
		// the sample right after a new high settles it
		if (breakout_open) begin
			if (usable && ret_count < COUNT_LIMIT) begin
				ret_sum   = ret_sum + breakout_return(breakout_price, p);
				ret_count = ret_count + 1'b1;
			end
			breakout_open  = 1'b0;
			breakout_price = '0;
		end
		if (!last) begin
			if (usable && (!high_valid || p > high_price)) begin
				high_price     = p;
				high_valid     = 1'b1;
				breakout_price = p;
				breakout_open  = 1'b1;
			end
		end else begin
			// series end: mean or empty flag, then start over
			if (ret_count == '0) begin
				m.mean = '0;
				m.has  = 1'b0;
			end else begin
				m.mean = series_mean(ret_sum, ret_count);
				m.has  = 1'b1;
			end
			expected_means.push_back(m);
			clear_series();
		end
	endtask

	task automatic check_mean();
		mean_exp_t want;
		if (expected_means.size() == 0) begin
			report_mismatch("result with none expected", results.mean_return, '0);
		end else begin
			want = expected_means.pop_front();
			if (results.mean_return !== want.mean)
				report_mismatch("mean_return", results.mean_return, want.mean);
			if (results.has_result !== want.has)
				report_mismatch("has_result", {31'd0, results.has_result}, {31'd0, want.has});
		end
		means_seen++;
	endtask

	// results first: a mean due now always stems from an earlier series end
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_series();
			expected_means.delete();
			means_waiting = 0;
		end else begin
			if (results.valid && results.ready) check_mean();
			if (samples.valid && samples.ready)
				take_sample(samples.price, samples.price_valid, samples.series_last);
			means_waiting = expected_means.size();
		end
	end

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives price series into the breakout next-return mean block: a directed
// set of edge cases, then random series in bursts, with a stalling result
// side, one long result hold-off and one full drain. The checker beside the
// block predicts every mean; this top gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import bnrm_pkg::*;

	localparam int unsigned RANDOM_ITEMS   = 480;
	localparam int unsigned MIN_SERIES     = 40;
	localparam int unsigned LONG_STALL     = 2500;
	localparam int unsigned DRAIN_CYCLES   = 200;
	localparam int unsigned WATCHDOG_LIMIT = 20000;

	logic clk;
	logic arst_n;

	bnrm_in_if  samples();
	bnrm_out_if results();

	int unsigned fail_count;
	int unsigned means_waiting;
	int unsigned burst_left = 0;
	int unsigned items_sent = 0;
	int unsigned series_done = 0;
	bit          long_stall_req = 1'b0;

	breakout_next_return_mean i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples),
		.results (results)
	);

	bnrm_mean_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.samples       (samples),
		.results       (results),
		.fail_count    (fail_count),
		.means_waiting (means_waiting)
	);

	// 12 ns clock
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// one sample request, with a random gap between bursts
	task automatic offer_sample(input logic [31:0] p, input logic pv, input logic last);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
			if (gap != 0) begin
				samples.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		samples.valid       <= 1'b1;
		samples.price       <= p;
		samples.price_valid <= pv;
		samples.series_last <= last;
		do @(posedge clk); while (!samples.ready);
		items_sent++;
	endtask

	// hold the sender until every expected mean has come out
	task automatic wait_for_means();
		samples.valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (means_waiting != 0);
	endtask

	// one random series; mostly a walking price, some wide, tiny and noisy ones
	task automatic random_series();
		int unsigned len;
		int unsigned style;
		int unsigned i;
		int          delta;
		longint      level;
		logic [31:0] p;
		logic        pv;
		len   = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 14);
		style = $urandom_range(0, 9);
		level = $urandom_range(50, 200000);
		for (i = 0; i < len; i++) begin
			pv = ($urandom_range(0, 15) != 0);
			case (style)
				0: p = $urandom;
				1: p = $urandom_range(0, 12);
				2: p = 32'hffff_ffff - $urandom_range(0, 1000);
				3: begin
					p  = $urandom_range(0, 300);
					pv = $urandom_range(0, 1);
				end
				default: begin
					delta = int'($urandom_range(0, 4000)) - 1800;
					level = level + delta;
					if (level < 1) level = 1 + $urandom_range(0, 50);
					p = level[31:0];
				end
			endcase
			if ($urandom_range(0, 19) == 0) p = '0;
			offer_sample(p, pv, i == len - 1);
		end
		series_done++;
	endtask

	// result side: stall patterns that change now and then, plus one long hold
	initial begin
		int unsigned mode;
		int unsigned phase_left;
		int unsigned hold_left;
		mode = 0;
		phase_left = 0;
		hold_left = 0;
		results.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_stall_req) begin
				hold_left = LONG_STALL;
				long_stall_req = 1'b0;
			end
			if (phase_left == 0) begin
				mode = $urandom_range(0, 3);
				phase_left = $urandom_range(50, 400);
			end
			phase_left--;
			if (hold_left > 0) begin
				hold_left--;
				results.ready <= 1'b0;
			end else begin
				case (mode)
					0: results.ready <= 1'b1;
					1: results.ready <= ($urandom_range(0, 3) != 0);
					2: results.ready <= ($urandom_range(0, 3) == 0);
					default: results.ready <= phase_left[2];
				endcase
			end
		end
	end

	// watchdog on cycles without a handshake on either channel
	initial begin
		int unsigned idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((samples.valid && samples.ready) || (results.valid && results.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("== FAIL ==");
		$finish;
	end

	// stimulus and verdict
	initial begin
		int unsigned random_base;
		bit          stall_done;
		bit          pause_done;
		stall_done = 1'b0;
		pause_done = 1'b0;
		arst_n              <= 1'b0;
		samples.valid       <= 1'b0;
		samples.price       <= '0;
		samples.price_valid <= 1'b0;
		samples.series_last <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single-sample series: empty mean
		offer_sample(32'd100, 1'b1, 1'b1);
		// tiny high then top price: saturated return, NaN settles the next high
		offer_sample(32'd1, 1'b1, 1'b0);
		offer_sample(32'hffff_ffff, 1'b1, 1'b0);
		offer_sample(32'd5, 1'b0, 1'b0);
		offer_sample(32'd7, 1'b1, 1'b1);
		// zero price settles without a return; last sample settles but is no high
		offer_sample(32'd200, 1'b1, 1'b0);
		offer_sample(32'd0, 1'b1, 1'b0);
		offer_sample(32'd300, 1'b1, 1'b0);
		offer_sample(32'd150, 1'b1, 1'b1);
		// only the very next sample settles; mixed signs truncate toward zero
		offer_sample(32'd100, 1'b1, 1'b0);
		offer_sample(32'd50, 1'b0, 1'b0);
		offer_sample(32'd120, 1'b1, 1'b0);
		offer_sample(32'd130, 1'b1, 1'b0);
		offer_sample(32'd91, 1'b1, 1'b1);
		// equal price is no new high
		offer_sample(32'd500, 1'b1, 1'b0);
		offer_sample(32'd500, 1'b1, 1'b0);
		offer_sample(32'd500, 1'b1, 1'b1);
		// alternating bit patterns and a NaN last sample
		offer_sample(32'h5555_5555, 1'b1, 1'b0);
		offer_sample(32'haaaa_aaaa, 1'b1, 1'b0);
		offer_sample(32'h7fff_ffff, 1'b0, 1'b1);

		// random series, with one long result hold-off and one full drain
		random_base = items_sent;
		while (items_sent - random_base < RANDOM_ITEMS || series_done < MIN_SERIES) begin
			if (!stall_done && items_sent - random_base > 150) begin
				long_stall_req = 1'b1;
				stall_done = 1'b1;
			end
			if (!pause_done && items_sent - random_base > 320) begin
				wait_for_means();
				pause_done = 1'b1;
			end
			random_series();
		end

		samples.valid <= 1'b0;
		do @(posedge clk); while (means_waiting != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && means_waiting == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
